/* rtl/assert_macros.svh */
// Assertion macros for the grid weight interpolator RTL (used by gwi_ctrl).
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
// When cond holds, nxt must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, cond, nxt)
`endif
`endif

/* rtl/gwi_pkg.sv */
// Package of the grid weight interpolator: sizes, codes, table entry layout,
// the arithmetic micro-program and the controller/datapath interface structs.
`timescale 1ns / 1ps

package gwi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W = 2;
  localparam int COL_W = 8;
  localparam int ID_W = 2 * COL_W;
  localparam int COORD_W = 24;
  localparam int WGT_W = 20;
  localparam int STAT_W = 3;

  localparam int IN_W = 2 * COL_W + 2 * COORD_W + 2 * WGT_W;
  localparam int OUT_W = 48;

  // Arithmetic widths.
  localparam int OPR_W = COORD_W + 2;
  localparam int PROD_W = 2 * OPR_W;
  localparam int NUM_W = PROD_W + 1;
  localparam int QUOT_W = NUM_W + 1;
  localparam int SAT_W = QUOT_W + 2;
  localparam int SQ_W = 2 * (COORD_W + 1);
  localparam int DIST_W = SQ_W + 1;
  localparam int TGT_W = COL_W + 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO_SPAN = 3'd4;

  localparam logic signed [SAT_W-1:0] WGT_HI = SAT_W'((2 ** (WGT_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] WGT_LO = -SAT_W'(2 ** (WGT_W - 1));
  localparam logic signed [SAT_W-1:0] CRD_HI = SAT_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] CRD_LO = -SAT_W'(2 ** (COORD_W - 1));

  typedef struct packed {
    logic signed [WGT_W-1:0] wy;
    logic signed [WGT_W-1:0] wx;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] px;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef enum logic [2:0] {K_MUL, K_LOAD, K_ADD, K_DIV, K_CHK, K_END} kind_t;

  typedef enum logic [3:0] {
    S_DA_WXB, S_DB_WXA, S_DA_WYB, S_DB_WYA, S_RY,
    S_DL_UX, S_DU_LX, S_DL_UY, S_DU_LY
  } sel_t;

  typedef enum logic [2:0] {D_WX, D_WY, D_RY, D_OX, D_OY} dst_t;

  typedef struct packed {
    kind_t kind;
    sel_t sel;
    dst_t dst;
    logic row;
  } prog_t;

  localparam int PROG_LEN = 38;
  localparam int STEP_W = $clog2(PROG_LEN);

  // Row 0 is the lower cell row (corners 0 and 1), row 1 the upper one.
  localparam prog_t PROG [PROG_LEN] = '{
    '{K_MUL, S_DA_WXB, D_WX, 1'b0}, '{K_LOAD, S_DA_WXB, D_WX, 1'b0},
    '{K_MUL, S_DB_WXA, D_WX, 1'b0}, '{K_ADD, S_DA_WXB, D_WX, 1'b0},
    '{K_DIV, S_DA_WXB, D_WX, 1'b0},
    '{K_MUL, S_DA_WYB, D_WY, 1'b0}, '{K_LOAD, S_DA_WXB, D_WY, 1'b0},
    '{K_MUL, S_DB_WYA, D_WY, 1'b0}, '{K_ADD, S_DA_WXB, D_WY, 1'b0},
    '{K_DIV, S_DA_WXB, D_WY, 1'b0},
    '{K_MUL, S_RY, D_RY, 1'b0}, '{K_LOAD, S_DA_WXB, D_RY, 1'b0},
    '{K_DIV, S_DA_WXB, D_RY, 1'b0},
    '{K_MUL, S_DA_WXB, D_WX, 1'b1}, '{K_LOAD, S_DA_WXB, D_WX, 1'b1},
    '{K_MUL, S_DB_WXA, D_WX, 1'b1}, '{K_ADD, S_DA_WXB, D_WX, 1'b1},
    '{K_DIV, S_DA_WXB, D_WX, 1'b1},
    '{K_MUL, S_DA_WYB, D_WY, 1'b1}, '{K_LOAD, S_DA_WXB, D_WY, 1'b1},
    '{K_MUL, S_DB_WYA, D_WY, 1'b1}, '{K_ADD, S_DA_WXB, D_WY, 1'b1},
    '{K_DIV, S_DA_WXB, D_WY, 1'b1},
    '{K_MUL, S_RY, D_RY, 1'b1}, '{K_LOAD, S_DA_WXB, D_RY, 1'b1},
    '{K_DIV, S_DA_WXB, D_RY, 1'b1},
    '{K_CHK, S_DA_WXB, D_OX, 1'b0},
    '{K_MUL, S_DL_UX, D_OX, 1'b0}, '{K_LOAD, S_DA_WXB, D_OX, 1'b0},
    '{K_MUL, S_DU_LX, D_OX, 1'b0}, '{K_ADD, S_DA_WXB, D_OX, 1'b0},
    '{K_DIV, S_DA_WXB, D_OX, 1'b0},
    '{K_MUL, S_DL_UY, D_OY, 1'b0}, '{K_LOAD, S_DA_WXB, D_OY, 1'b0},
    '{K_MUL, S_DU_LY, D_OY, 1'b0}, '{K_ADD, S_DA_WXB, D_OY, 1'b0},
    '{K_DIV, S_DA_WXB, D_OY, 1'b0},
    '{K_END, S_DA_WXB, D_OX, 1'b0}
  };

  typedef struct packed {
    logic load_item;
    logic wr_en;
    logic rd_en;
    logic scan1;
    logic scan2;
    logic setup;
    logic mul_en;
    logic acc_load;
    logic acc_add;
    logic div_start;
    logic div_write;
    logic out_load;
    logic out_ok;
    logic [ADDR_W-1:0] addr;
    prog_t prog;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic all_found;
    logic zero_span;
    logic total_zero;
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [OPR_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
    sdiff = OPR_W'(a) - OPR_W'(b);
  endfunction

  function automatic logic signed [OPR_W-1:0] adiff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
    logic signed [OPR_W-1:0] d;
    d = sdiff(a, b);
    adiff = (d < 0) ? -d : d;
  endfunction

  function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [SAT_W-1:0] v);
    if (v > WGT_HI) sat_wgt = WGT_HI[WGT_W-1:0];
    else if (v < WGT_LO) sat_wgt = WGT_LO[WGT_W-1:0];
    else sat_wgt = v[WGT_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_crd(input logic signed [SAT_W-1:0] v);
    if (v > CRD_HI) sat_crd = CRD_HI[COORD_W-1:0];
    else if (v < CRD_LO) sat_crd = CRD_LO[COORD_W-1:0];
    else sat_crd = v[COORD_W-1:0];
  endfunction

endpackage

/* rtl/gwi_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gwi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/gwi_div.sv */
// Rounding signed divider, one quotient bit per cycle (restoring).
// Depends on gwi_pkg. Result rounds to nearest, ties away from zero.
`timescale 1ns / 1ps

module gwi_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [gwi_pkg::PROD_W-1:0] num,
  input  logic signed [gwi_pkg::OPR_W-1:0]  den,
  output logic                              done,
  output logic signed [gwi_pkg::QUOT_W-1:0] quot
);
  import gwi_pkg::*;

  localparam int CNT_DW = $clog2(NUM_W);

  logic              busy;
  logic [CNT_DW-1:0] cnt;
  logic              neg;
  logic [OPR_W-1:0]  dmag;
  logic [OPR_W-1:0]  rem;
  logic [NUM_W-1:0]  sh;

  logic [PROD_W-1:0] nmag;
  logic [OPR_W-1:0]  dmag_in;
  logic [OPR_W:0]    trial;
  logic              qbit;

  always_comb begin
    nmag = (num < 0) ? PROD_W'(-num) : PROD_W'(num);
    dmag_in = (den < 0) ? OPR_W'(-den) : OPR_W'(den);
    trial = {rem, sh[NUM_W-1]};
    qbit = (trial >= {1'b0, dmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      // The last iteration raises done for exactly one cycle.
      done <= busy && !start && (cnt == CNT_DW'(NUM_W - 1));
      if (start) begin
        // Adding half the divisor up front turns truncation into rounding.
        sh <= NUM_W'(nmag) + NUM_W'(dmag_in >> 1);
        rem <= '0;
        dmag <= dmag_in;
        neg <= (num < 0) != (den < 0);
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= qbit ? OPR_W'(trial - {1'b0, dmag}) : OPR_W'(trial);
        sh <= {sh[NUM_W-2:0], qbit};
        if (cnt == CNT_DW'(NUM_W - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed({1'b0, sh}) : $signed({1'b0, sh});

endmodule

/* rtl/gwi_dp.sv */
// Datapath of the grid weight interpolator: point table, nearest-point scan
// pipeline, corner search, multiply/accumulate and divider. Depends on gwi_pkg.
`timescale 1ns / 1ps

module gwi_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  gwi_pkg::cmd_t                    cmd,
  output gwi_pkg::dp_stat_t                stat,
  input  logic [gwi_pkg::OP_W-1:0]         in_op,
  input  logic [gwi_pkg::IN_W-1:0]         in_data,
  output logic signed [gwi_pkg::WGT_W-1:0] res_wx,
  output logic signed [gwi_pkg::WGT_W-1:0] res_wy
);
  import gwi_pkg::*;

  // Item registers.
  logic [OP_W-1:0]           op;
  logic [COL_W-1:0]          icol;
  logic [COL_W-1:0]          irow;
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic signed [WGT_W-1:0]   iwx;
  logic signed [WGT_W-1:0]   iwy;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op <= in_op;
      {iwy, iwx, qy, qx, irow, icol} <= in_data;
    end
  end

  // Point table.
  entry_t wentry;
  entry_t rentry;
  logic [$bits(entry_t)-1:0] rword;

  always_comb begin
    wentry.id = {icol, irow};
    wentry.px = qx;
    wentry.py = qy;
    wentry.wx = iwx;
    wentry.wy = iwy;
    rentry = entry_t'(rword);
  end

  gwi_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(cmd.addr),
    .wdata(wentry),
    .re   (cmd.rd_en),
    .raddr(cmd.addr),
    .rdata(rword)
  );

  // Tags that travel with each read.
  logic t1;
  logic t2;
  logic t1_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= 1'b0;
      t2 <= 1'b0;
    end else begin
      t1 <= cmd.rd_en && cmd.scan1;
      t2 <= cmd.rd_en && cmd.scan2;
    end
    t1_first <= (cmd.addr == '0);
  end

  // Nearest-point pipeline: difference, square, compare.
  logic                      a_v, a_first;
  logic [ID_W-1:0]           a_id;
  logic signed [OPR_W-1:0]   ex, ey;
  logic                      b_v, b_first, b_gx, b_gy;
  logic [ID_W-1:0]           b_id;
  logic [SQ_W-1:0]           sqx, sqy;
  logic [DIST_W-1:0]         best;
  logic [ID_W-1:0]           near_id;
  logic                      near_gx, near_gy;
  logic [COORD_W:0]          mx, my;
  logic [DIST_W-1:0]         sq_dist;

  always_comb begin
    mx = (ex < 0) ? (COORD_W + 1)'(-ex) : (COORD_W + 1)'(ex);
    my = (ey < 0) ? (COORD_W + 1)'(-ey) : (COORD_W + 1)'(ey);
    sq_dist = DIST_W'(sqx) + DIST_W'(sqy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      a_v <= t1;
      b_v <= a_v;
    end
    a_first <= t1_first;
    a_id <= rentry.id;
    ex <= sdiff(qx, rentry.px);
    ey <= sdiff(qy, rentry.py);
    b_first <= a_first;
    b_id <= a_id;
    b_gx <= (ex > 0);
    b_gy <= (ey > 0);
    sqx <= mx * mx;
    sqy <= my * my;
    if (b_v && (b_first || sq_dist < best)) begin
      best <= sq_dist;
      near_id <= b_id;
      near_gx <= b_gx;
      near_gy <= b_gy;
    end
  end

  // Corner search.
  logic [TGT_W-1:0]          tcol0, tcol1, trow0, trow1;
  logic [3:0]                found;
  logic [3:0]                tvalid;
  logic [ID_W-1:0]           tid [4];
  logic signed [COORD_W-1:0] c_px [4];
  logic signed [COORD_W-1:0] c_py [4];
  logic signed [WGT_W-1:0]   c_wx [4];
  logic signed [WGT_W-1:0]   c_wy [4];
  logic [TGT_W-1:0]          bc, br;

  always_comb begin
    bc = TGT_W'(near_id[ID_W-1:COL_W]) - TGT_W'(!near_gx);
    br = TGT_W'(near_id[COL_W-1:0]) - TGT_W'(!near_gy);
    tid[0] = {tcol0[COL_W-1:0], trow0[COL_W-1:0]};
    tid[1] = {tcol1[COL_W-1:0], trow0[COL_W-1:0]};
    tid[2] = {tcol0[COL_W-1:0], trow1[COL_W-1:0]};
    tid[3] = {tcol1[COL_W-1:0], trow1[COL_W-1:0]};
    // A corner outside the ID range can never be found.
    tvalid[0] = (tcol0[TGT_W-1:COL_W] == '0) && (trow0[TGT_W-1:COL_W] == '0);
    tvalid[1] = (tcol1[TGT_W-1:COL_W] == '0) && (trow0[TGT_W-1:COL_W] == '0);
    tvalid[2] = (tcol0[TGT_W-1:COL_W] == '0) && (trow1[TGT_W-1:COL_W] == '0);
    tvalid[3] = (tcol1[TGT_W-1:COL_W] == '0) && (trow1[TGT_W-1:COL_W] == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      tcol0 <= bc;
      tcol1 <= bc + 1'b1;
      trow0 <= br;
      trow1 <= br + 1'b1;
      found <= '0;
    end else if (t2) begin
      for (int k = 0; k < 4; k++) begin
        if (!found[k] && tvalid[k] && rentry.id == tid[k]) begin
          found[k] <= 1'b1;
          c_px[k] <= rentry.px;
          c_py[k] <= rentry.py;
          c_wx[k] <= rentry.wx;
          c_wy[k] <= rentry.wy;
        end
      end
    end
  end

  // Multiply, accumulate and divide.
  logic signed [WGT_W-1:0]   wxr [2];
  logic signed [WGT_W-1:0]   wyr [2];
  logic signed [COORD_W-1:0] ryr [2];
  logic signed [WGT_W-1:0]   ox, oy;
  logic signed [OPR_W-1:0]   op1, op2, den;
  logic signed [PROD_W-1:0]  prod, acc;
  logic signed [COORD_W-1:0] pa, pb;
  logic [1:0]                ia, ib;
  logic                      div_done;
  logic signed [QUOT_W-1:0]  quot;

  always_comb begin
    ia = {cmd.prog.row, 1'b1};
    ib = {cmd.prog.row, 1'b0};
    pa = c_px[ia];
    pb = c_px[ib];
    case (cmd.prog.sel)
      S_DA_WXB: begin op1 = adiff(qx, pa); op2 = OPR_W'(c_wx[ib]); end
      S_DB_WXA: begin op1 = adiff(qx, pb); op2 = OPR_W'(c_wx[ia]); end
      S_DA_WYB: begin op1 = adiff(qx, pa); op2 = OPR_W'(c_wy[ib]); end
      S_DB_WYA: begin op1 = adiff(qx, pb); op2 = OPR_W'(c_wy[ia]); end
      S_RY:     begin op1 = sdiff(qx, pb); op2 = sdiff(c_py[ia], c_py[ib]); end
      S_DL_UX:  begin op1 = adiff(qy, ryr[0]); op2 = OPR_W'(wxr[1]); end
      S_DU_LX:  begin op1 = adiff(qy, ryr[1]); op2 = OPR_W'(wxr[0]); end
      S_DL_UY:  begin op1 = adiff(qy, ryr[0]); op2 = OPR_W'(wyr[1]); end
      S_DU_LY:  begin op1 = adiff(qy, ryr[1]); op2 = OPR_W'(wyr[0]); end
      default:  begin op1 = '0; op2 = '0; end
    endcase
    case (cmd.prog.dst)
      D_WX, D_WY: den = adiff(pa, pb);
      D_RY:       den = sdiff(pa, pb);
      default:    den = adiff(ryr[0], ryr[1]);
    endcase
  end

  gwi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (acc),
    .den  (den),
    .done (div_done),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= op1 * op2;
    end
    if (cmd.acc_load) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
    if (cmd.div_write) begin
      case (cmd.prog.dst)
        D_WX:    wxr[cmd.prog.row] <= sat_wgt(SAT_W'(quot));
        D_WY:    wyr[cmd.prog.row] <= sat_wgt(SAT_W'(quot));
        D_RY:    ryr[cmd.prog.row] <= sat_crd(SAT_W'(c_py[ib]) + SAT_W'(quot));
        D_OX:    ox <= sat_wgt(SAT_W'(quot));
        D_OY:    oy <= sat_wgt(SAT_W'(quot));
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      res_wx <= cmd.out_ok ? ox : '0;
      res_wy <= cmd.out_ok ? oy : '0;
    end
  end

  always_comb begin
    stat.op = op;
    stat.all_found = &found;
    stat.zero_span = (c_px[3] == c_px[2]) || (c_px[1] == c_px[0]);
    stat.total_zero = (ryr[0] == ryr[1]);
    stat.div_done = div_done;
  end

endmodule

/* rtl/gwi_ctrl.sv */
// Controller of the grid weight interpolator: item handshake, fill count,
// scan sequencing, micro-program stepping and result slot. Depends on gwi_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gwi_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gwi_pkg::STAT_W-1:0]  out_status,
  output gwi_pkg::cmd_t               cmd,
  input  gwi_pkg::dp_stat_t           stat
);
  import gwi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN1, S_DRAIN1, S_SETUP2, S_SCAN2, S_DRAIN2,
    S_CHECK, S_RUN, S_DIVW, S_FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] scan_idx;
  logic [1:0]        drain;
  logic [STEP_W-1:0] step;
  logic [STAT_W-1:0] status;
  logic              slot_free;
  prog_t             p;

  assign in_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign p = PROG[step];

  always_comb begin
    cmd = '0;
    cmd.prog = p;
    cmd.addr = scan_idx;
    case (state)
      S_IDLE: cmd.load_item = in_valid;
      S_DISPATCH: begin
        cmd.addr = count[ADDR_W-1:0];
        cmd.wr_en = (stat.op == OP_APPEND) && (count != CNT_W'(TABLE_DEPTH));
      end
      S_SCAN1: begin
        cmd.rd_en = 1'b1;
        cmd.scan1 = 1'b1;
      end
      S_SETUP2: cmd.setup = 1'b1;
      S_SCAN2: begin
        cmd.rd_en = 1'b1;
        cmd.scan2 = 1'b1;
      end
      S_RUN: begin
        case (p.kind)
          K_MUL:   cmd.mul_en = 1'b1;
          K_LOAD:  cmd.acc_load = 1'b1;
          K_ADD:   cmd.acc_add = 1'b1;
          K_DIV:   cmd.div_start = 1'b1;
          default: ;
        endcase
      end
      S_DIVW: cmd.div_write = stat.div_done;
      S_FINISH: begin
        cmd.out_load = slot_free;
        // Only a query that ends well carries weights.
        cmd.out_ok = (status == ST_OK) && (stat.op == OP_QUERY);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      scan_idx <= '0;
      drain <= '0;
      step <= '0;
      status <= ST_OK;
      out_status <= ST_OK;
    end else begin
      if (state == S_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (stat.op)
            OP_CLEAR: begin
              count <= '0;
              status <= ST_OK;
              state <= S_FINISH;
            end
            OP_APPEND: begin
              state <= S_FINISH;
              if (count == CNT_W'(TABLE_DEPTH)) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
                count <= count + 1'b1;
              end
            end
            OP_QUERY: begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state <= S_FINISH;
              end else begin
                status <= ST_OK;
                scan_idx <= '0;
                state <= S_SCAN1;
              end
            end
            default: begin
              status <= ST_OK;
              state <= S_FINISH;
            end
          endcase
        end
        S_SCAN1: begin
          if (CNT_W'(scan_idx) == count - 1'b1) begin
            drain <= '0;
            state <= S_DRAIN1;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN1: begin
          if (drain == 2'd2) begin
            state <= S_SETUP2;
          end else begin
            drain <= drain + 1'b1;
          end
        end
        S_SETUP2: begin
          scan_idx <= '0;
          state <= S_SCAN2;
        end
        S_SCAN2: begin
          if (CNT_W'(scan_idx) == count - 1'b1) begin
            state <= S_DRAIN2;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN2: state <= S_CHECK;
        S_CHECK: begin
          if (!stat.all_found) begin
            status <= ST_MISSING;
            state <= S_FINISH;
          end else if (stat.zero_span) begin
            status <= ST_ZERO_SPAN;
            state <= S_FINISH;
          end else begin
            step <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          case (p.kind)
            K_DIV: state <= S_DIVW;
            K_CHK: begin
              if (stat.total_zero) begin
                status <= ST_ZERO_SPAN;
                state <= S_FINISH;
              end else begin
                step <= step + 1'b1;
              end
            end
            K_END: begin
              status <= ST_OK;
              state <= S_FINISH;
            end
            default: step <= step + 1'b1;
          endcase
        end
        S_DIVW: begin
          if (stat.div_done) begin
            step <= step + 1'b1;
            state <= S_RUN;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_status <= status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_HOLDS(a_count_bound, clk, rst, count <= CNT_W'(TABLE_DEPTH))
  `ASSERT_HOLDS(a_scan_in_fill, clk, rst, (state != S_SCAN1) || (CNT_W'(scan_idx) < count))
  `ASSERT_NEXT(a_accept_dispatch, clk, rst, in_valid && in_ready, state == S_DISPATCH)

endmodule

/* rtl/grid_weight_interpolator.sv */
// Top level of the grid weight interpolator: stream ports, controller and
// datapath. Depends on gwi_pkg, gwi_ctrl, gwi_dp and, below them, gwi_ram, gwi_div.
`timescale 1ns / 1ps

// The block keeps a table of up to TABLE_DEPTH grid points (column/row ID,
// measured position, x/y weight) and takes one item at a time: clear the
// table, append a point, or query a position. Every item yields exactly one
// result item. For a query, the single table read port is swept twice, once
// to find the nearest point through a three-stage distance pipeline and once
// to find the four cell corners, and the eight rounded divisions of the
// bilinear blend go through one divider that yields one quotient bit per
// cycle. Queries that end early (empty table, missing corner, zero span) skip
// the remaining work. A finished result waits in the output register while
// the next item is already accepted; the table holds no reset state besides
// its fill count, so the block is ready right after reset.

module grid_weight_interpolator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // grid_col[7:0], grid_row[15:8], coord_x[39:16], coord_y[63:40],
  // x_weight[83:64], y_weight[103:84]
  input  logic [gwi_pkg::IN_W-1:0]    s_axis_tdata,
  // operation[1:0]
  input  logic [gwi_pkg::OP_W-1:0]    s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_weight_x[19:0], out_weight_y[39:20], status[42:40], zero [47:43]
  output logic [gwi_pkg::OUT_W-1:0]   m_axis_tdata
);
  import gwi_pkg::*;

  cmd_t                    cmd;
  dp_stat_t                stat;
  logic [STAT_W-1:0]       status;
  logic signed [WGT_W-1:0] res_wx;
  logic signed [WGT_W-1:0] res_wy;

  // The controller sequences every item and owns the result handshake.
  gwi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_status(status),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the table, the scans and the arithmetic.
  gwi_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .in_op  (s_axis_tuser),
    .in_data(s_axis_tdata),
    .res_wx (res_wx),
    .res_wy (res_wy)
  );

  // Result weights are already forced to zero when the status is not ok.
  assign m_axis_tdata = {(OUT_W - 2 * WGT_W - STAT_W)'(0), status, res_wy, res_wx};

endmodule
